// File: rtl/sws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sws_pkg;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_DUMP   = 3'd2,
    OP_SEARCH = 3'd3,
    OP_SORT   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 40;

endpackage

`default_nettype wire

// File: rtl/stack_with_search_and_sort.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tdata: op[2:0], value[34:3]
// m_axis    out  tvalid/tready, tlast   tdata: status[1:0], data[33:2], position[36:34]
//
// One request at a time. For N stored words, sort makes up to N passes over the
// single read and single write port of the entry memory.
// Reset clears the fill count and control state; memory contents are not reset.
// A stalled output holds the walk in place; a new request is taken while the
// last result still waits in the output register.

module stack_with_search_and_sort #(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [sws_pkg::InTdataW-1:0]  s_axis_tdata,   // op, value
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [sws_pkg::OutTdataW-1:0]      m_axis_tdata,   // status, data, position
  output logic                               m_axis_tlast
);
  import sws_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_RESP       = 3'd1;
  localparam logic [2:0] S_POP_RD     = 3'd2;
  localparam logic [2:0] S_SCAN       = 3'd3;
  localparam logic [2:0] S_SRCH_FIN   = 3'd4;
  localparam logic [2:0] S_SORT_FIRST = 3'd5;
  localparam logic [2:0] S_SORT_RUN   = 3'd6;
  localparam logic [2:0] S_SORT_END   = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [CW-1:0] cur_idx_q, cur_idx_d;
  logic          rv_q, rv_d;
  logic          is_dump_q, is_dump_d;
  logic          pend_q, pend_d;
  logic [2:0]    pend_pos_q, pend_pos_d;
  logic          swapped_q, swapped_d;
  word_t         key_q, key_d;
  word_t         carry_q, carry_d;

  status_e       resp_status_q, resp_status_d;
  word_t         resp_data_q, resp_data_d;
  logic [2:0]    resp_pos_q, resp_pos_d;

  logic          out_valid_q, out_valid_d;
  status_e       out_status_q, out_status_d;
  word_t         out_data_q, out_data_d;
  logic [2:0]    out_pos_q, out_pos_d;
  logic          out_last_q, out_last_d;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  word_t         wr_data, rd_data;

  logic          in_req, out_free, consume, match, more, scan_done;
  op_e           in_op;
  word_t         in_value;
  logic [CW-1:0] cnt_m1, wr_run;
  logic [CW+2:0] cur_ext;
  logic [2:0]    cur_pos;

  assign in_op    = op_e'(s_axis_tdata[2:0]);
  assign in_value = s_axis_tdata[34:3];
  assign in_req   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign cnt_m1   = cnt_q - CW'(1);
  assign wr_run   = rd_idx_q - CW'(2);
  assign cur_ext  = {3'b000, cur_idx_q};
  assign cur_pos  = cur_ext[2:0];
  assign match    = (rd_data == key_q);
  assign more     = (rd_idx_q < cnt_q);

  always_comb begin
    if (is_dump_q) begin
      consume = rv_q && out_free;
    end else begin
      consume = rv_q && (!(match && pend_q) || out_free);
    end
  end

  assign scan_done = !more && (!rv_q || consume);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    rd_idx_d      = rd_idx_q;
    cur_idx_d     = cur_idx_q;
    rv_d          = rv_q;
    is_dump_d     = is_dump_q;
    pend_d        = pend_q;
    pend_pos_d    = pend_pos_q;
    swapped_d     = swapped_q;
    key_d         = key_q;
    carry_d       = carry_q;
    resp_status_d = resp_status_q;
    resp_data_d   = resp_data_q;
    resp_pos_d    = resp_pos_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_status_d  = out_status_q;
    out_data_d    = out_data_q;
    out_pos_d     = out_pos_q;
    out_last_d    = out_last_q;
    wr_en         = 1'b0;
    wr_addr       = cnt_q[AW-1:0];
    wr_data       = in_value;
    rd_en         = 1'b0;
    rd_addr       = rd_idx_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_req) begin
          key_d         = in_value;
          resp_status_d = ST_OK;
          resp_data_d   = '0;
          resp_pos_d    = '0;
          rd_idx_d      = '0;
          rv_d          = 1'b0;
          pend_d        = 1'b0;
          case (in_op)
            OP_PUSH: begin
              if (cnt_q == CW'(DEPTH)) begin
                resp_status_d = ST_FULL;
              end else begin
                wr_en = 1'b1;
                cnt_d = cnt_q + CW'(1);
              end
              state_d = S_RESP;
            end
            OP_POP: begin
              if (cnt_q == '0) begin
                resp_status_d = ST_EMPTY;
                state_d       = S_RESP;
              end else begin
                rd_en   = 1'b1;
                rd_addr = cnt_m1[AW-1:0];
                cnt_d   = cnt_m1;
                state_d = S_POP_RD;
              end
            end
            OP_DUMP: begin
              is_dump_d = 1'b1;
              if (cnt_q == '0) begin
                resp_status_d = ST_EMPTY;
                state_d       = S_RESP;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_SEARCH: begin
              is_dump_d = 1'b0;
              state_d   = S_SCAN;
            end
            OP_SORT: begin
              if (cnt_q < CW'(2)) begin
                state_d = S_RESP;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                swapped_d = 1'b0;
                state_d   = S_SORT_FIRST;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = resp_status_q;
          out_data_d   = resp_data_q;
          out_pos_d    = resp_pos_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      S_POP_RD: begin
        resp_data_d = rd_data;
        state_d     = S_RESP;
      end

      S_SCAN: begin
        if (consume) begin
          if (is_dump_q) begin
            out_valid_d  = 1'b1;
            out_status_d = ST_OK;
            out_data_d   = rd_data;
            out_pos_d    = cur_pos;
            out_last_d   = (cur_idx_q == cnt_m1);
          end else if (match) begin
            if (pend_q) begin
              out_valid_d  = 1'b1;
              out_status_d = ST_OK;
              out_data_d   = key_q;
              out_pos_d    = pend_pos_q;
              out_last_d   = 1'b0;
            end
            pend_d     = 1'b1;
            pend_pos_d = cur_pos;
          end
        end
        if ((!rv_q || consume) && more) begin
          rd_en     = 1'b1;
          rd_idx_d  = rd_idx_q + CW'(1);
          cur_idx_d = rd_idx_q;
          rv_d      = 1'b1;
        end else if (consume) begin
          rv_d = 1'b0;
        end
        if (scan_done) begin
          state_d = is_dump_q ? S_IDLE : S_SRCH_FIN;
        end
      end

      S_SRCH_FIN: begin
        if (pend_q) begin
          resp_status_d = ST_OK;
          resp_data_d   = key_q;
          resp_pos_d    = pend_pos_q;
        end else begin
          resp_status_d = ST_NOT_FOUND;
        end
        state_d = S_RESP;
      end

      S_SORT_FIRST: begin
        carry_d  = rd_data;
        rd_en    = 1'b1;
        rd_addr  = AW'(1);
        rd_idx_d = CW'(2);
        state_d  = S_SORT_RUN;
      end

      S_SORT_RUN: begin
        wr_en   = 1'b1;
        wr_addr = wr_run[AW-1:0];
        if ($signed(rd_data) < $signed(carry_q)) begin
          wr_data   = rd_data;
          swapped_d = 1'b1;
        end else begin
          wr_data = carry_q;
          carry_d = rd_data;
        end
        if (more) begin
          rd_en    = 1'b1;
          rd_idx_d = rd_idx_q + CW'(1);
        end else begin
          state_d = S_SORT_END;
        end
      end

      S_SORT_END: begin
        wr_en   = 1'b1;
        wr_addr = cnt_m1[AW-1:0];
        wr_data = carry_q;
        if (swapped_q) begin
          rd_en     = 1'b1;
          rd_addr   = '0;
          swapped_d = 1'b0;
          state_d   = S_SORT_FIRST;
        end else begin
          state_d = S_RESP;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  sws_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rv_q        <= 1'b0;
      pend_q      <= 1'b0;
      swapped_q   <= 1'b0;
      is_dump_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rv_q        <= rv_d;
      pend_q      <= pend_d;
      swapped_q   <= swapped_d;
      is_dump_q   <= is_dump_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q      <= rd_idx_d;
    cur_idx_q     <= cur_idx_d;
    pend_pos_q    <= pend_pos_d;
    key_q         <= key_d;
    carry_q       <= carry_d;
    resp_status_q <= resp_status_d;
    resp_data_q   <= resp_data_d;
    resp_pos_q    <= resp_pos_d;
    out_status_q  <= out_status_d;
    out_data_q    <= out_data_d;
    out_pos_q     <= out_pos_d;
    out_last_q    <= out_last_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {3'b000, out_pos_q, out_data_q, out_status_q};

endmodule

`default_nettype wire

// File: rtl/sws_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sws_ram #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire sws_pkg::word_t wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output sws_pkg::word_t     rd_data_o
);
  import sws_pkg::*;

  word_t mem [DEPTH];
  word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: verif/stack_with_search_and_sort_checker.sv
`timescale 1ns / 1ps

module stack_with_search_and_sort_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  input  logic                          req_ready_i,
  input  logic [sws_pkg::InTdataW-1:0]  req_data_i,   // op[2:0], value[34:3]
  input  logic                          rsp_valid_i,
  input  logic                          rsp_ready_i,
  input  logic [sws_pkg::OutTdataW-1:0] rsp_data_i,   // status[1:0], data[33:2], position[36:34]
  input  logic                          rsp_last_i,
  output int                            mismatch_count_o,
  output int                            pending_o
);
  import sws_pkg::*;

  localparam int Depth = 8;

  typedef struct {
    status_e    status;
    word_t      data;
    logic [2:0] position;
    logic       last;
  } reply_t;

  reply_t reply_q[$];
  word_t  stack_mem[Depth];
  int     fill = 0;
  int     mismatch_n = 0;
  int     pending_n = 0;

  assign mismatch_count_o = mismatch_n;
  assign pending_o        = pending_n;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_n++;
    $display("%0t ns: %s mismatch: got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic add_reply(input status_e st, input word_t d, input logic [2:0] p,
                           input logic l);
    reply_t r;
    r.status   = st;
    r.data     = d;
    r.position = p;
    r.last     = l;
    reply_q.push_back(r);
  endtask

  task automatic apply_stack_cmd(input logic [2:0] op, input word_t key);
    int    hits;
    int    seen;
    int    j;
    word_t cur;
    hits = 0;
    seen = 0;
    case (op)
      OP_PUSH: begin
        if (fill >= Depth) begin
          add_reply(ST_FULL, '0, '0, 1'b1);
        end else begin
          stack_mem[fill] = key;
          fill++;
          add_reply(ST_OK, '0, '0, 1'b1);
        end
      end
      OP_POP: begin
        if (fill == 0) begin
          add_reply(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          fill--;
          add_reply(ST_OK, stack_mem[fill], '0, 1'b1);
        end
      end
      OP_DUMP: begin
        if (fill == 0) begin
          add_reply(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < fill; i++)
            add_reply(ST_OK, stack_mem[i], 3'(i), (i == fill - 1));
        end
      end
      OP_SEARCH: begin
        for (int i = 0; i < fill; i++)
          if (stack_mem[i] == key) hits++;
        if (hits == 0) begin
          add_reply(ST_NOT_FOUND, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < fill; i++) begin
            if (stack_mem[i] == key) begin
              seen++;
              add_reply(ST_OK, key, 3'(i), (seen == hits));
            end
          end
        end
      end
      OP_SORT: begin
        for (int i = 1; i < fill; i++) begin
          cur = stack_mem[i];
          j = i;
          while (j > 0 && $signed(cur) < $signed(stack_mem[j-1])) begin
            stack_mem[j] = stack_mem[j-1];
            j--;
          end
          stack_mem[j] = cur;
        end
        add_reply(ST_OK, '0, '0, 1'b1);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    reply_t want;
    if (!rst_ni) begin
      fill = 0;
      reply_q.delete();
    end else begin
      if (req_valid_i && req_ready_i)
        apply_stack_cmd(req_data_i[2:0], req_data_i[34:3]);
      if (rsp_valid_i && rsp_ready_i) begin
        if (reply_q.size() == 0) begin
          report_mismatch("unrequested result, data", rsp_data_i[33:2], '0);
        end else begin
          want = reply_q.pop_front();
          if (rsp_data_i[1:0] != want.status)
            report_mismatch("status", rsp_data_i[1:0], want.status);
          if (rsp_data_i[33:2] != want.data)
            report_mismatch("data", rsp_data_i[33:2], want.data);
          if (rsp_data_i[36:34] != want.position)
            report_mismatch("position", rsp_data_i[36:34], want.position);
          if (rsp_last_i !== want.last)
            report_mismatch("tlast", rsp_last_i, want.last);
        end
      end
    end
    pending_n = reply_q.size();
  end

endmodule

// File: verif/stack_with_search_and_sort_tb.sv
`timescale 1ns / 1ps

module stack_with_search_and_sort_tb;
  import sws_pkg::*;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;   // op[2:0], value[34:3]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;   // status[1:0], data[33:2], position[36:34]
  logic                 m_axis_tlast;

  int    mismatches;
  int    pending;
  bit    tx_gaps_on;
  bit    rx_stalls_on;
  word_t pool[8];

  stack_with_search_and_sort #(.DEPTH(8)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  stack_with_search_and_sort_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (s_axis_tvalid),
    .req_ready_i      (s_axis_tready),
    .req_data_i       (s_axis_tdata),
    .rsp_valid_i      (m_axis_tvalid),
    .rsp_ready_i      (m_axis_tready),
    .rsp_data_i       (m_axis_tdata),
    .rsp_last_i       (m_axis_tlast),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("stack_with_search_and_sort test failed");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // stall the result side
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      int stall;
      @(negedge clk_i);
      stall = rx_stalls_on ? idle_len() : 0;
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      repeat ($urandom_range(0, 7)) @(negedge clk_i);
    end
  end

  task automatic send_cmd(input logic [2:0] op, input word_t val);
    int gap;
    gap = tx_gaps_on ? idle_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {5'b0, val, op};
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic word_t pick_word(input int pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  initial begin
    int    issued;
    int    r;
    int    push_w;
    int    pop_w;
    bit    fill_up;
    word_t v;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    tx_gaps_on    = 1'b1;
    rx_stalls_on  = 1'b1;
    pool[0] = 32'h7FFF_FFFF;
    pool[1] = 32'h8000_0000;
    pool[2] = 32'h0000_0000;
    pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 8; i++) pool[i] = $urandom;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_cmd(OP_POP,    '0);
    send_cmd(OP_DUMP,   '0);
    send_cmd(OP_SEARCH, '0);
    send_cmd(OP_SORT,   '0);
    send_cmd(OP_PUSH,   32'h7FFF_FFFF);
    send_cmd(OP_SORT,   '0);
    send_cmd(OP_PUSH,   32'h8000_0000);
    send_cmd(OP_PUSH,   32'hFFFF_FFFF);
    send_cmd(OP_PUSH,   32'h0000_0000);
    send_cmd(OP_PUSH,   32'h7FFF_FFFF);
    send_cmd(OP_PUSH,   32'h5555_5555);
    send_cmd(OP_PUSH,   32'hAAAA_AAAA);
    send_cmd(OP_PUSH,   32'hFFFF_FFFF);
    send_cmd(OP_PUSH,   32'h0000_0001);
    send_cmd(OP_DUMP,   '0);
    send_cmd(OP_SEARCH, 32'h7FFF_FFFF);
    send_cmd(OP_SEARCH, 32'h1234_5678);
    wait_drained();
    send_cmd(3'd5, $urandom);
    send_cmd(3'd6, $urandom);
    send_cmd(3'd7, $urandom);
    send_cmd(OP_SORT,   '0);
    send_cmd(OP_DUMP,   '0);
    send_cmd(OP_SEARCH, 32'hFFFF_FFFF);
    send_cmd(OP_POP,    '0);
    send_cmd(OP_POP,    '0);

    issued  = 0;
    fill_up = 1'b1;
    while (issued < 435) begin
      if (issued % 40 == 0) begin
        fill_up      = ~fill_up;
        tx_gaps_on   = ($urandom_range(0, 3) != 0);
        rx_stalls_on = ($urandom_range(0, 3) != 0);
      end
      if (issued % 90 == 89) wait_drained();
      if ($urandom_range(0, 9) == 0) pool[$urandom_range(0, 7)] = $urandom;
      push_w = fill_up ? 45 : 15;
      pop_w  = fill_up ? 15 : 40;
      r = $urandom_range(0, 99);
      if (r < push_w) begin
        send_cmd(OP_PUSH, pick_word(60));
      end else if (r < push_w + pop_w) begin
        send_cmd(OP_POP, $urandom);
      end else if (r < push_w + pop_w + 12) begin
        send_cmd(OP_DUMP, $urandom);
      end else if (r < push_w + pop_w + 28) begin
        send_cmd(OP_SEARCH, pick_word(75));
      end else if (r < push_w + pop_w + 35) begin
        send_cmd(OP_SORT, $urandom);
      end else begin
        v = $urandom;
        send_cmd(3'($urandom_range(5, 7)), v);
      end
      issued++;
    end

    wait_drained();
    repeat (150) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("stack_with_search_and_sort test passed");
    end else begin
      $display("stack_with_search_and_sort test failed");
    end
    $finish;
  end

endmodule
